// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level core.
// No dependencies; defining ASSERT_OFF compiles the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/rapq_pkg.sv -----
// Constants and types of the range-add point-query tree.
// Used by the interfaces, the controller, the datapath and the top level.
package rapq_pkg;

	localparam int MAX_ELEMENTS = 4096;
	localparam int TREE_NODES   = 4 * MAX_ELEMENTS;
	localparam int RESET_COUNT  = 4096;

	localparam int OP_W  = 2;
	localparam int POS_W = 13;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;
	localparam int ID_W  = $clog2(TREE_NODES);

	// one pending right sibling per tree level at most
	localparam int STK_DEPTH = 2 ** $clog2($clog2(MAX_ELEMENTS) + 1);
	localparam int SP_W      = $clog2(STK_DEPTH) + 1;

	localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_ELEMENTS);
	localparam logic [POS_W-1:0] RESET_POS = POS_W'(RESET_COUNT);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		RAM_IDLE,
		RAM_CLR,
		RAM_RD_NODE,
		RAM_RD_LEFT,
		RAM_RD_RIGHT,
		RAM_WR_ZERO,
		RAM_WR_LEFT,
		RAM_WR_RIGHT,
		RAM_WR_LEAF,
		RAM_WR_ADD
	} ram_op_t;

	typedef struct packed {
		logic             pend;
		logic [SUM_W-1:0] sum;
	} node_t;

	typedef struct packed {
		ram_op_t ram;
		logic    cap;
		logic    desc;
		logic    split;
		logic    pop;
		logic    hold;
		logic    acc;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic load_ok;
		logic add_ok;
		logic query_ok;
		logic leaf;
		logic pend;
		logic disjoint;
		logic covered;
		logic stk_empty;
		logic stk_full;
		logic clr_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/rapq_ifs.sv -----
// Handshake channels of the range-add point-query tree: item, result, config.
// Depends on rapq_pkg.
interface rapq_item_if;
	logic                           valid;
	logic                           ready;
	logic [rapq_pkg::OP_W-1:0]      op;
	logic [rapq_pkg::POS_W-1:0]     first_index;
	logic [rapq_pkg::POS_W-1:0]     last_index;
	logic signed [rapq_pkg::VAL_W-1:0] value;

	modport source (output valid, op, first_index, last_index, value, input ready);
	modport sink (input valid, op, first_index, last_index, value, output ready);
endinterface

interface rapq_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [rapq_pkg::SUM_W-1:0] point_sum;

	modport source (output valid, point_sum, input ready);
	modport sink (input valid, point_sum, output ready);
endinterface

interface rapq_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rapq_pkg::POS_W-1:0] element_count;

	modport source (output valid, element_count, input ready);
	modport sink (input valid, element_count, output ready);
endinterface

// ----- rtl/rapq_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module rapq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/rapq_dp.sv -----
// Datapath: node store, walk registers, span stack, accumulator, result register.
// Depends on rapq_pkg and rapq_ram.
module rapq_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rapq_pkg::POS_W-1:0]  cfg_data,
	input  logic [rapq_pkg::OP_W-1:0]   item_op,
	input  logic [rapq_pkg::POS_W-1:0]  item_first,
	input  logic [rapq_pkg::POS_W-1:0]  item_last,
	input  logic [rapq_pkg::VAL_W-1:0]  item_value,
	input  rapq_pkg::cmd_t              cmd,
	output rapq_pkg::sts_t              sts,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [rapq_pkg::SUM_W-1:0]  res_sum
);

	typedef struct packed {
		logic [rapq_pkg::ID_W-1:0]  id;
		logic [rapq_pkg::POS_W-1:0] b;
		logic [rapq_pkg::POS_W-1:0] e;
	} frame_t;

	function automatic logic [rapq_pkg::SUM_W-1:0] sat_add(
		input logic [rapq_pkg::SUM_W-1:0] x,
		input logic [rapq_pkg::SUM_W-1:0] y
	);
		logic [rapq_pkg::SUM_W-1:0] s;
		s = x + y;
		if (x[rapq_pkg::SUM_W-1] == y[rapq_pkg::SUM_W-1] &&
		    s[rapq_pkg::SUM_W-1] != x[rapq_pkg::SUM_W-1]) begin
			s = x[rapq_pkg::SUM_W-1] ? {1'b1, {(rapq_pkg::SUM_W-1){1'b0}}}
			                         : {1'b0, {(rapq_pkg::SUM_W-1){1'b1}}};
		end
		return s;
	endfunction

	logic [rapq_pkg::POS_W-1:0] cfg_q;
	logic [rapq_pkg::ID_W-1:0]  clr_q;
	logic                       clr_done_q;
	logic [rapq_pkg::SP_W-1:0]  sp_q;
	logic                       res_valid_q;

	rapq_pkg::op_t              op_q;
	logic [rapq_pkg::POS_W-1:0] n_q;
	logic [rapq_pkg::POS_W-1:0] fi_q;
	logic [rapq_pkg::POS_W-1:0] i_q;
	logic [rapq_pkg::POS_W-1:0] j_q;
	logic [rapq_pkg::VAL_W-1:0] v_q;
	logic [rapq_pkg::ID_W-1:0]  id_q;
	logic [rapq_pkg::POS_W-1:0] b_q;
	logic [rapq_pkg::POS_W-1:0] e_q;
	logic [rapq_pkg::SUM_W-1:0] par_q;
	logic [rapq_pkg::SUM_W-1:0] acc_q;
	logic [rapq_pkg::SUM_W-1:0] res_sum_q;
	frame_t                     stk_q [rapq_pkg::STK_DEPTH];

	logic [rapq_pkg::POS_W-1:0] act_n;
	logic [rapq_pkg::POS_W:0]   mid_sum;
	logic [rapq_pkg::POS_W-1:0] mid;
	logic [rapq_pkg::POS_W-1:0] mid_p1;
	logic [rapq_pkg::ID_W-1:0]  left_id;
	logic [rapq_pkg::ID_W-1:0]  right_id;
	logic                       go_left;
	logic [rapq_pkg::SP_W-1:0]  sp_m1;
	frame_t                     top;
	logic [rapq_pkg::SUM_W-1:0] v_ext;

	logic                         ram_we;
	logic [rapq_pkg::ID_W-1:0]    ram_addr;
	rapq_pkg::node_t              ram_wdata;
	logic [$bits(rapq_pkg::node_t)-1:0] ram_rdata;
	rapq_pkg::node_t              rd;

	// count 0 acts as 1, anything above the tree size as the tree size
	always_comb begin
		if (cfg_q == '0) begin
			act_n = rapq_pkg::POS_W'(1);
		end else if (cfg_q > rapq_pkg::MAX_POS) begin
			act_n = rapq_pkg::MAX_POS;
		end else begin
			act_n = cfg_q;
		end
	end

	assign mid_sum  = {1'b0, b_q} + {1'b0, e_q};
	assign mid      = mid_sum[rapq_pkg::POS_W:1];
	assign mid_p1   = mid + 1'b1;
	assign left_id  = {id_q[rapq_pkg::ID_W-2:0], 1'b0};
	assign right_id = {id_q[rapq_pkg::ID_W-2:0], 1'b1};
	assign go_left  = fi_q <= mid;
	assign sp_m1    = sp_q - 1'b1;
	assign top      = stk_q[sp_m1[rapq_pkg::SP_W-2:0]];
	assign v_ext    = {{(rapq_pkg::SUM_W-rapq_pkg::VAL_W){v_q[rapq_pkg::VAL_W-1]}}, v_q};
	assign rd       = rapq_pkg::node_t'(ram_rdata);

	always_comb begin
		ram_we    = 1'b1;
		ram_addr  = id_q;
		ram_wdata = '0;
		case (cmd.ram)
			rapq_pkg::RAM_CLR: begin
				ram_addr = clr_q;
			end
			rapq_pkg::RAM_RD_NODE: begin
				ram_we = 1'b0;
			end
			rapq_pkg::RAM_RD_LEFT: begin
				ram_we   = 1'b0;
				ram_addr = left_id;
			end
			rapq_pkg::RAM_RD_RIGHT: begin
				ram_we   = 1'b0;
				ram_addr = right_id;
			end
			rapq_pkg::RAM_WR_ZERO: begin
				ram_wdata = '0;
			end
			rapq_pkg::RAM_WR_LEFT: begin
				ram_addr  = left_id;
				ram_wdata = '{pend: 1'b1, sum: sat_add(rd.sum, par_q)};
			end
			rapq_pkg::RAM_WR_RIGHT: begin
				ram_addr  = right_id;
				ram_wdata = '{pend: 1'b1, sum: sat_add(rd.sum, par_q)};
			end
			rapq_pkg::RAM_WR_LEAF: begin
				ram_wdata = '{pend: 1'b0, sum: v_ext};
			end
			rapq_pkg::RAM_WR_ADD: begin
				ram_wdata = '{pend: 1'b1, sum: sat_add(rd.sum, v_ext)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rapq_ram #(
		.WIDTH ($bits(rapq_pkg::node_t)),
		.DEPTH (rapq_pkg::TREE_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= rapq_pkg::RESET_POS;
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (cmd.ram == rapq_pkg::RAM_CLR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == rapq_pkg::ID_W'(rapq_pkg::TREE_NODES - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.cap) begin
				sp_q <= '0;
			end else if (cmd.split) begin
				sp_q <= sp_q + 1'b1;
			end else if (cmd.pop) begin
				sp_q <= sp_m1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= rapq_pkg::op_t'(item_op);
			n_q   <= act_n;
			fi_q  <= item_first;
			i_q   <= (item_first == '0) ? rapq_pkg::POS_W'(1) : item_first;
			j_q   <= (item_last > act_n) ? act_n : item_last;
			v_q   <= item_value;
			id_q  <= rapq_pkg::ID_W'(1);
			b_q   <= rapq_pkg::POS_W'(1);
			e_q   <= act_n;
			acc_q <= '0;
		end else begin
			if (cmd.pop) begin
				id_q <= top.id;
				b_q  <= top.b;
				e_q  <= top.e;
			end else if (cmd.split) begin
				id_q <= left_id;
				e_q  <= mid;
			end else if (cmd.desc) begin
				if (go_left) begin
					id_q <= left_id;
					e_q  <= mid;
				end else begin
					id_q <= right_id;
					b_q  <= mid_p1;
				end
			end
			if (cmd.acc) begin
				acc_q <= sat_add(acc_q, rd.sum);
			end
		end
		if (cmd.split) begin
			stk_q[sp_q[rapq_pkg::SP_W-2:0]] <= '{id: right_id, b: mid_p1, e: e_q};
		end
		if (cmd.hold) begin
			par_q <= rd.sum;
		end
		if (cmd.emit) begin
			res_sum_q <= acc_q;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.load_ok   = (fi_q != '0) && (fi_q <= n_q);
		sts.query_ok  = (fi_q != '0) && (fi_q <= n_q);
		sts.add_ok    = i_q <= j_q;
		sts.leaf      = b_q >= e_q;
		sts.pend      = rd.pend;
		sts.disjoint  = (b_q > j_q) || (e_q < i_q);
		sts.covered   = (b_q >= i_q) && (e_q <= j_q);
		sts.stk_empty = sp_q == '0;
		sts.stk_full  = sp_q[rapq_pkg::SP_W-1];
		sts.clr_done  = clr_done_q;
		sts.out_free  = !res_valid_q || res_ready;
	end

	assign res_valid = res_valid_q;
	assign res_sum   = res_sum_q;

endmodule

// ----- rtl/rapq_ctrl.sv -----
// Controller: sequences the clearing pass, loads, range adds and point queries.
// Depends on rapq_pkg.
module rapq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  rapq_pkg::sts_t sts,
	output rapq_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_L_CHK,
		ST_L_PEND,
		ST_L_RDL,
		ST_L_WRL,
		ST_L_RDR,
		ST_L_WRR,
		ST_A_VISIT,
		ST_A_UPD,
		ST_Q_RD,
		ST_Q_ACC,
		ST_Q_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end else begin
					cmd.ram = rapq_pkg::RAM_CLR;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					rapq_pkg::OP_LOAD:  state_d = sts.load_ok ? ST_L_CHK : ST_IDLE;
					rapq_pkg::OP_ADD:   state_d = sts.add_ok ? ST_A_VISIT : ST_IDLE;
					rapq_pkg::OP_QUERY: state_d = sts.query_ok ? ST_Q_RD : ST_Q_OUT;
					default:            state_d = ST_IDLE;
				endcase
			end
			// load: push pending adds down the path, then overwrite the leaf
			ST_L_CHK: begin
				if (sts.leaf) begin
					cmd.ram = rapq_pkg::RAM_WR_LEAF;
					state_d = ST_IDLE;
				end else begin
					cmd.ram = rapq_pkg::RAM_RD_NODE;
					state_d = ST_L_PEND;
				end
			end
			ST_L_PEND: begin
				if (sts.pend) begin
					cmd.ram  = rapq_pkg::RAM_WR_ZERO;
					cmd.hold = 1'b1;
					state_d  = ST_L_RDL;
				end else begin
					cmd.desc = 1'b1;
					state_d  = ST_L_CHK;
				end
			end
			ST_L_RDL: begin
				cmd.ram = rapq_pkg::RAM_RD_LEFT;
				state_d = ST_L_WRL;
			end
			ST_L_WRL: begin
				cmd.ram = rapq_pkg::RAM_WR_LEFT;
				state_d = ST_L_RDR;
			end
			ST_L_RDR: begin
				cmd.ram = rapq_pkg::RAM_RD_RIGHT;
				state_d = ST_L_WRR;
			end
			ST_L_WRR: begin
				cmd.ram  = rapq_pkg::RAM_WR_RIGHT;
				cmd.desc = 1'b1;
				state_d  = ST_L_CHK;
			end
			// range add: depth-first walk, right siblings parked on the stack
			ST_A_VISIT: begin
				if (sts.disjoint) begin
					if (sts.stk_empty) begin
						state_d = ST_IDLE;
					end else begin
						cmd.pop = 1'b1;
					end
				end else if (sts.covered) begin
					cmd.ram = rapq_pkg::RAM_RD_NODE;
					state_d = ST_A_UPD;
				end else begin
					cmd.split = 1'b1;
				end
			end
			ST_A_UPD: begin
				cmd.ram = rapq_pkg::RAM_WR_ADD;
				if (sts.stk_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_A_VISIT;
				end
			end
			ST_Q_RD: begin
				cmd.ram = rapq_pkg::RAM_RD_NODE;
				state_d = ST_Q_ACC;
			end
			ST_Q_ACC: begin
				cmd.acc = 1'b1;
				if (sts.leaf) begin
					state_d = ST_Q_OUT;
				end else begin
					cmd.desc = 1'b1;
					state_d  = ST_Q_RD;
				end
			end
			ST_Q_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/range_add_point_query_tree_core.sv -----
// Segment tree over positions 1..element_count with range add and point query.
// Items are taken one at a time; the single-port node memory does one access per
// cycle and sets the pace. A point query reads each node on the path from the
// root to the leaf and adds its sum. A load walks the same path, pushes any
// pending add down to both children on the way, then overwrites the leaf. A
// range add walks the tree depth first and adds the value to each node it
// reaches whose span lies inside the range. A query whose result word is still
// waiting in the output register holds until that word is taken. After reset
// the node store is cleared one entry a cycle, all 16384 entries, during which
// no item is taken; configuration writes are always taken. Depends on rapq_pkg,
// rapq_ifs, rapq_ctrl, rapq_dp and assert_macros.svh.
`include "assert_macros.svh"

module range_add_point_query_tree_core (
	input  logic          clk,
	input  logic          arst_n,
	rapq_item_if.sink     item,
	rapq_result_if.source result,
	rapq_cfg_if.sink      cfg
);

	rapq_pkg::cmd_t cmd;
	rapq_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	rapq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	rapq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.element_count),
		.item_op    (item.op),
		.item_first (item.first_index),
		.item_last  (item.last_index),
		.item_value (item.value),
		.cmd        (cmd),
		.sts        (sts),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_sum    (result.point_sum)
	);

	`ASSERT_PROP(a_ready_after_clear, clk, arst_n, item.ready |-> sts.clr_done, "early item")
	`ASSERT_PROP(a_result_from_query, clk, arst_n, $rose(result.valid) |-> $past(cmd.emit), "stray word")
	`ASSERT_NEVER(a_stack_room, clk, arst_n, cmd.split && sts.stk_full, "span stack overflow")

endmodule
